>>> design/hla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hla_pkg
// Shared types and constants of the compacting region allocator.
// ----------------------------------------------------------------------------
package hla_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int ADDR_BITS_DEF   = 32;
    localparam logic [31:0] TOTAL_SIZE_RST = 32'd16777216;

    // APB byte address of the total_size register
    localparam logic [1:0] ADDR_TOTAL_SIZE = 2'd0;

    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NOOWNER = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIT_RD,
        S_FIT_CHK,
        S_SUM_RD,
        S_SUM_CHK,
        S_CMP_RD,
        S_CMP_WR,
        S_SPLIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start_op;    // latch input item
        logic do_init;
        logic clr_i;       // scan index to 0
        logic inc_i;
        logic rd_i;        // issue read at scan index
        logic fit_chk;     // update fit candidate
        logic sum_chk;     // accumulate free bytes, flag a free entry
        logic cmp_start;   // set write index 1, next = merged
        logic cmp_wr;      // move occupied entry
        logic cmp_fin;     // write entry 0, set count
        logic split_rd;    // read entry k
        logic split_go;    // apply owner, start shifting
        logic shift_rd;
        logic shift_wr;
        logic shift_fin;   // write new free entry
        logic free_chk;
        logic set_status;
        logic [1:0] status;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic owner_zero;
        logic need_gt_free;
        logic scan_end;     // scan index == count
        logic fit_found;
        logic rd_hit;       // read owner == request owner
        logic nfree_zero;
        logic rest_zero;
        logic table_full;
        logic shift_end;    // shift index == k+1
        logic compacted;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

>>> design/hla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hla_ctrl
// Sequencer for init, allocate (scan, compact, split) and free.
// ----------------------------------------------------------------------------
module hla_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  hla_pkg::t_sts      i_sts,
    output logic               o_ready,
    output hla_pkg::t_cmd      o_cmd
);

    hla_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hla_pkg::S_IDLE: if (i_start) n_state = hla_pkg::S_DISPATCH;
            hla_pkg::S_DISPATCH: begin
                if (i_sts.action == hla_pkg::ACT_ALLOC) begin
                    if (i_sts.owner_zero || i_sts.need_gt_free) n_state = hla_pkg::S_DONE;
                    else n_state = hla_pkg::S_FIT_RD;
                end else if (i_sts.action == hla_pkg::ACT_FREE) begin
                    if (i_sts.owner_zero) n_state = hla_pkg::S_DONE;
                    else n_state = hla_pkg::S_FREE_RD;
                end else begin
                    n_state = hla_pkg::S_DONE;
                end
            end
            hla_pkg::S_FIT_RD: begin
                if (!i_sts.scan_end) n_state = hla_pkg::S_FIT_CHK;
                else if (i_sts.fit_found) n_state = hla_pkg::S_SPLIT;
                else if (i_sts.compacted) n_state = hla_pkg::S_DONE;
                else n_state = hla_pkg::S_SUM_RD;
            end
            hla_pkg::S_FIT_CHK: n_state = hla_pkg::S_FIT_RD;
            hla_pkg::S_SUM_RD: begin
                if (!i_sts.scan_end) n_state = hla_pkg::S_SUM_CHK;
                else if (i_sts.nfree_zero) n_state = hla_pkg::S_DONE;
                else n_state = hla_pkg::S_CMP_RD;
            end
            hla_pkg::S_SUM_CHK: n_state = hla_pkg::S_SUM_RD;
            hla_pkg::S_CMP_RD: begin
                if (!i_sts.scan_end) n_state = hla_pkg::S_CMP_WR;
                else n_state = hla_pkg::S_FIT_RD;
            end
            hla_pkg::S_CMP_WR: n_state = hla_pkg::S_CMP_RD;
            hla_pkg::S_SPLIT: begin
                if (!i_sts.rest_zero && i_sts.table_full) n_state = hla_pkg::S_DONE;
                else if (i_sts.rest_zero) n_state = hla_pkg::S_DONE;
                else n_state = hla_pkg::S_SHIFT_RD;
            end
            hla_pkg::S_SHIFT_RD: begin
                if (i_sts.shift_end) n_state = hla_pkg::S_DONE;
                else n_state = hla_pkg::S_SHIFT_WR;
            end
            hla_pkg::S_SHIFT_WR: n_state = hla_pkg::S_SHIFT_RD;
            hla_pkg::S_FREE_RD: begin
                if (i_sts.scan_end) n_state = hla_pkg::S_DONE;
                else n_state = hla_pkg::S_FREE_CHK;
            end
            hla_pkg::S_FREE_CHK: begin
                if (i_sts.rd_hit) n_state = hla_pkg::S_DONE;
                else n_state = hla_pkg::S_FREE_RD;
            end
            hla_pkg::S_DONE: if (!i_sts.out_busy) n_state = hla_pkg::S_IDLE;
            default: n_state = hla_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        unique case (r_state)
            hla_pkg::S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.start_op = i_start;
            end
            hla_pkg::S_DISPATCH: begin
                o_cmd.clr_i = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status = hla_pkg::ST_OK;
                if (i_sts.action == hla_pkg::ACT_INIT) o_cmd.do_init = 1'b1;
                if ((i_sts.action == hla_pkg::ACT_ALLOC || i_sts.action == hla_pkg::ACT_FREE)
                    && i_sts.owner_zero) o_cmd.status = hla_pkg::ST_NOOWNER;
                else if (i_sts.action == hla_pkg::ACT_ALLOC && i_sts.need_gt_free)
                    o_cmd.status = hla_pkg::ST_NOSPACE;
            end
            hla_pkg::S_FIT_RD: begin
                o_cmd.rd_i = 1'b1;
                if (i_sts.scan_end) begin
                    o_cmd.clr_i = 1'b1;
                    if (i_sts.fit_found) o_cmd.split_rd = 1'b1;
                    else if (i_sts.compacted) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = hla_pkg::ST_NOSPACE;
                    end
                end
            end
            hla_pkg::S_FIT_CHK: begin
                o_cmd.fit_chk = 1'b1;
                o_cmd.inc_i = 1'b1;
            end
            hla_pkg::S_SUM_RD: begin
                o_cmd.rd_i = 1'b1;
                if (i_sts.scan_end) begin
                    o_cmd.clr_i = 1'b1;
                    if (i_sts.nfree_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = hla_pkg::ST_NOSPACE;
                    end else begin
                        o_cmd.cmp_start = 1'b1;
                    end
                end
            end
            hla_pkg::S_SUM_CHK: begin
                o_cmd.sum_chk = 1'b1;
                o_cmd.inc_i = 1'b1;
            end
            hla_pkg::S_CMP_RD: begin
                o_cmd.rd_i = 1'b1;
                if (i_sts.scan_end) begin
                    o_cmd.cmp_fin = 1'b1;
                    o_cmd.clr_i = 1'b1;
                end
            end
            hla_pkg::S_CMP_WR: begin
                o_cmd.cmp_wr = 1'b1;
                o_cmd.inc_i = 1'b1;
            end
            hla_pkg::S_SPLIT: begin
                if (!i_sts.rest_zero && i_sts.table_full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = hla_pkg::ST_FULL;
                end else begin
                    o_cmd.split_go = 1'b1;
                end
            end
            hla_pkg::S_SHIFT_RD: begin
                if (i_sts.shift_end) o_cmd.shift_fin = 1'b1;
                else o_cmd.shift_rd = 1'b1;
            end
            hla_pkg::S_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            hla_pkg::S_FREE_RD: begin
                o_cmd.rd_i = 1'b1;
                if (i_sts.scan_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = hla_pkg::ST_NOOWNER;
                end
            end
            hla_pkg::S_FREE_CHK: begin
                o_cmd.free_chk = 1'b1;
                o_cmd.inc_i = 1'b1;
            end
            hla_pkg::S_DONE: o_cmd.out_load = !i_sts.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> design/hla_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hla_datapath
// Region table memory, scan index, fit/compact/split/free arithmetic.
// ----------------------------------------------------------------------------
module hla_datapath #(
    parameter int MAX_REGIONS = hla_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = hla_pkg::ADDR_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  hla_pkg::t_cmd      i_cmd,
    input  wire logic [1:0]    i_action,
    input  wire logic [15:0]   i_owner,
    input  wire logic [31:0]   i_need,
    input  wire logic [31:0]   i_total_size,
    input  wire logic          i_out_ready,
    output hla_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [31:0]        o_base,
    output logic [31:0]        o_free
);

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int EW = ADDR_BITS + 32 + 16;

    // entry: {start, size, owner}
    logic [EW-1:0] r_mem [MAX_REGIONS];
    logic [EW-1:0] r_rd;

    logic [1:0]   r_action;
    logic [15:0]  r_owner;
    logic [31:0]  r_need;
    logic [CW-1:0] r_count;
    logic [31:0]  r_free;
    logic [CW-1:0] r_i;       // scan / shift index
    logic [CW-1:0] r_w;       // compaction write index
    logic [ADDR_BITS-1:0] r_next;
    logic [31:0]  r_merged;
    logic         r_nfree;
    logic         r_found;
    logic [IW-1:0] r_k;
    logic         r_compacted;
    logic [1:0]   r_status;
    logic [31:0]  r_base;
    logic [ADDR_BITS-1:0] r_kstart;
    logic [31:0]  r_rest;
    logic         r_oval;
    logic [1:0]   r_ost;
    logic [31:0]  r_obase, r_ofree;

    logic [ADDR_BITS-1:0] rd_start;
    logic [31:0]  rd_size;
    logic [15:0]  rd_owner;
    assign rd_start = r_rd[EW-1 -: ADDR_BITS];
    assign rd_size  = r_rd[47:16];
    assign rd_owner = r_rd[15:0];

    // memory: one write port, one registered read port
    logic          we;
    logic [IW-1:0] wa;
    logic [EW-1:0] wd;
    logic          re;
    logic [IW-1:0] ra;

    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        re = 1'b0;
        ra = r_i[IW-1:0];
        if (i_cmd.do_init) begin
            we = 1'b1;
            wd = {{ADDR_BITS{1'b0}}, i_total_size, 16'd0};
        end else if (i_cmd.cmp_wr && rd_owner != 16'd0) begin
            we = 1'b1;
            wa = r_w[IW-1:0];
            wd = {r_next, rd_size, rd_owner};
        end else if (i_cmd.cmp_fin) begin
            we = 1'b1;
            wd = {{ADDR_BITS{1'b0}}, r_merged, 16'd0};
        end else if (i_cmd.split_go) begin
            we = 1'b1;
            wa = r_k;
            wd = {rd_start, r_need, r_owner};
        end else if (i_cmd.shift_wr) begin
            we = 1'b1;
            wa = r_i[IW-1:0];
            wd = r_rd;
        end else if (i_cmd.shift_fin) begin
            we = 1'b1;
            wa = r_k + IW'(1);
            wd = {r_kstart, r_rest, 16'd0};
        end else if (i_cmd.free_chk && rd_owner == r_owner) begin
            we = 1'b1;
            wa = r_i[IW-1:0];
            wd = {rd_start, rd_size, 16'd0};
        end
        if (i_cmd.rd_i) re = 1'b1;
        if (i_cmd.split_rd) begin
            re = 1'b1;
            ra = r_k;
        end
        if (i_cmd.shift_rd) begin
            re = 1'b1;
            ra = IW'(r_i - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (re) r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_free <= '0;
            r_i <= '0;
            r_oval <= 1'b0;
        end else begin
            if (i_cmd.start_op) begin
                r_action <= i_action;
                r_owner <= i_owner;
                r_need <= i_need;
                r_found <= 1'b0;
                r_compacted <= 1'b0;
                r_merged <= '0;
                r_nfree <= 1'b0;
                r_base <= '0;
            end
            if (i_cmd.do_init) begin
                r_count <= CW'(1);
                r_free <= i_total_size;
            end
            if (i_cmd.clr_i) r_i <= '0;
            if (i_cmd.inc_i) r_i <= r_i + CW'(1);
            if (i_cmd.set_status) r_status <= i_cmd.status;
            if (i_cmd.fit_chk && rd_owner == 16'd0 && rd_size >= r_need) begin
                r_found <= 1'b1;
                r_k <= r_i[IW-1:0];
            end
            if (i_cmd.sum_chk && rd_owner == 16'd0) begin
                r_merged <= r_merged + rd_size;
                r_nfree <= 1'b1;
            end
            if (i_cmd.cmp_start) begin
                r_w <= CW'(1);
                r_next <= ADDR_BITS'(r_merged);
                r_compacted <= 1'b1;
            end
            if (i_cmd.cmp_wr && rd_owner != 16'd0) begin
                r_w <= r_w + CW'(1);
                r_next <= r_next + ADDR_BITS'(rd_size);
            end
            if (i_cmd.cmp_fin) r_count <= r_w;
            if (i_cmd.split_go) begin
                r_free <= r_free - r_need;
                r_base <= 32'(rd_start);
                r_kstart <= rd_start + ADDR_BITS'(r_need);
                r_rest <= rd_size - r_need;
                r_i <= r_count;
                if (rd_size != r_need) r_count <= r_count + CW'(1);
            end
            if (i_cmd.shift_wr) r_i <= r_i - CW'(1);
            if (i_cmd.free_chk && rd_owner == r_owner) r_free <= r_free + rd_size;
            if (i_cmd.out_load) begin
                r_oval <= 1'b1;
                r_ost <= r_status;
                r_obase <= r_base;
                r_ofree <= (i_cmd.split_go) ? r_free : r_free;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts = '0;
        o_sts.action = r_action;
        o_sts.owner_zero = (r_owner == 16'd0);
        o_sts.need_gt_free = (r_need > r_free);
        o_sts.scan_end = (r_i == r_count);
        o_sts.fit_found = r_found;
        o_sts.rd_hit = (rd_owner == r_owner);
        o_sts.nfree_zero = !r_nfree;
        o_sts.rest_zero = (rd_size == r_need);
        o_sts.table_full = (r_count >= CW'(MAX_REGIONS));
        o_sts.shift_end = (r_i == CW'(r_k) + CW'(1));
        o_sts.compacted = r_compacted;
        o_sts.out_busy = r_oval && !i_out_ready;
    end

    assign o_out_valid = r_oval;
    assign o_status = r_ost;
    assign o_base = r_obase;
    assign o_free = r_ofree;

endmodule
`default_nettype wire

>>> design/hole_list_allocator_compacting.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hole_list_allocator_compacting
// Address-ordered region allocator with compaction, stream in/out, APB cfg.
// ----------------------------------------------------------------------------
// Sequence: init, unused code and rejects go straight to the result; alloc runs a
// fit scan, then shifts entries up for a split, and when no hole fits compacts
// and runs a second fit scan; free scans entries until the owner hits or the table ends.
// Throughput: one beat in flight; the next beat is taken in the cycle after the
// result is loaded, later while the result waits.
// Reset: count, free bytes and total_size register reset; table is undefined.
module hole_list_allocator_compacting #(
    parameter int MAX_REGIONS = hla_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = hla_pkg::ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // action[1:0], owner_id[17:2], request_size[49:18]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // status[1:0], base_address[33:2], free_bytes[65:34]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] r_total_size;
    hla_pkg::t_cmd cmd;
    hla_pkg::t_sts sts;
    logic [1:0]  st;
    logic [31:0] base, fr;

    assign pready = 1'b1;
    assign prdata = (paddr == hla_pkg::ADDR_TOTAL_SIZE) ? r_total_size : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= hla_pkg::TOTAL_SIZE_RST;
        end else if (psel && penable && pwrite && paddr == hla_pkg::ADDR_TOTAL_SIZE) begin
            r_total_size <= pwdata;
        end
    end

    hla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_axis_tvalid),
        .i_sts   (sts),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    hla_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (s_axis_tdata[1:0]),
        .i_owner      (s_axis_tdata[17:2]),
        .i_need       (s_axis_tdata[49:18]),
        .i_total_size (r_total_size),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (st),
        .o_base       (base),
        .o_free       (fr)
    );

    assign m_axis_tdata = {6'd0, fr, base, st};

endmodule
`default_nettype wire
